/* src/htt_pkg.sv */
// ----------------------------------------------------------------------------
// htt_pkg: shared types and constants
// Register codes, item payload types and the word that travels along the
// square-root and divider cell rows.
// ----------------------------------------------------------------------------
package htt_pkg;

   // tolerances on errors, Q16.16
   localparam logic [31:0] MOVE_POS_TOL   = 32'd655;
   localparam logic [31:0] MOVE_VEL_TOL   = 32'd655;
   localparam logic [31:0] TURN_ANGLE_TOL = 32'd655;
   localparam logic [31:0] TURN_RATE_TOL  = 32'd655;
   localparam logic [63:0] MOVE_POS_TOL_SQ = 64'(MOVE_POS_TOL) * 64'(MOVE_POS_TOL);
   localparam logic [63:0] MOVE_VEL_TOL_SQ = 64'(MOVE_VEL_TOL) * 64'(MOVE_VEL_TOL);

   // cell row lengths: one root bit per sqrt cell, one quotient bit per div cell
   localparam int SQRT_CELLS = 32;
   localparam int DIV_CELLS  = 31;

   typedef enum logic [2:0] {
      CSR_MOVE_FF_GAIN  = 3'd0,
      CSR_MOVE_POS_GAIN = 3'd1,
      CSR_MOVE_VEL_GAIN = 3'd2,
      CSR_TURN_FF_GAIN  = 3'd3,
      CSR_TURN_ANG_GAIN = 3'd4,
      CSR_TURN_RATE_GAIN = 3'd5,
      CSR_MOVE_LIMIT    = 3'd6,
      CSR_TURN_LIMIT    = 3'd7
   } htt_csr_type;

   typedef struct packed {
      logic [31:0] plan_x;
      logic [31:0] plan_y;
      logic [31:0] plan_vx;
      logic [31:0] plan_vy;
      logic [31:0] plan_heading;
      logic [31:0] plan_turn_rate;
      logic [31:0] meas_x;
      logic [31:0] meas_y;
      logic [31:0] meas_vx;
      logic [31:0] meas_vy;
      logic [31:0] meas_heading;
      logic [31:0] meas_turn_rate;
   } htt_in_type;

   typedef struct packed {
      logic [31:0] move_ff;
      logic [31:0] move_pos;
      logic [31:0] move_vel;
      logic [31:0] turn_ff;
      logic [31:0] turn_ang;
      logic [31:0] turn_rate;
      logic [30:0] move_lim;
      logic [30:0] turn_lim;
   } htt_cfg_type;

   // word handed from cell to cell
   typedef struct packed {
      logic        vld;
      logic        sx;
      logic        sy;
      logic        over;
      logic [63:0] n;
      logic [63:0] root;
      logic [63:0] remx;
      logic [63:0] remy;
      logic [30:0] qx;
      logic [30:0] qy;
      logic [31:0] cx;
      logic [31:0] cy;
      logic [31:0] cr;
   } htt_cell_type;

   function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) sat_diff = d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
      else sat_diff = d[31:0];
   endfunction

   function automatic logic [31:0] sat64(input logic [63:0] v);
      if ($signed(v) > 64'sh7fff_ffff) sat64 = 32'h7fff_ffff;
      else if ($signed(v) < -64'sh8000_0000) sat64 = 32'h8000_0000;
      else sat64 = v[31:0];
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] v);
      abs32 = v[31] ? 32'(-v) : v;
   endfunction

endpackage

/* src/htt_if.sv */
// ----------------------------------------------------------------------------
// htt_if: channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface htt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] plan_x, plan_y, plan_vx, plan_vy, plan_heading, plan_turn_rate;
   logic [31:0] meas_x, meas_y, meas_vx, meas_vy, meas_heading, meas_turn_rate;
   modport source (output valid, plan_x, plan_y, plan_vx, plan_vy, plan_heading,
      plan_turn_rate, meas_x, meas_y, meas_vx, meas_vy, meas_heading, meas_turn_rate,
      input ready);
   modport sink (input valid, plan_x, plan_y, plan_vx, plan_vy, plan_heading,
      plan_turn_rate, meas_x, meas_y, meas_vx, meas_vy, meas_heading, meas_turn_rate,
      output ready);
endinterface

interface htt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cmd_vx, cmd_vy, cmd_turn_rate;
   modport source (output valid, cmd_vx, cmd_vy, cmd_turn_rate, input ready);
   modport sink (input valid, cmd_vx, cmd_vy, cmd_turn_rate, output ready);
endinterface

interface htt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* src/htt_front.sv */
// ----------------------------------------------------------------------------
// htt_front: error, gain and limit-test pipeline
// Five stages: errors, products, saturated sums, squares, length test.
// Feeds the square-root cell row.
// ----------------------------------------------------------------------------
module htt_front
   import htt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_vld,
   input  htt_in_type   in_item,
   input  htt_cfg_type  cfg,
   output htt_cell_type out_cell
);

   // stage A: saturated errors
   logic        a_vld_ff;
   logic [31:0] ex_ff, ey_ff, evx_ff, evy_ff, ea_ff, er_ff, pvx_ff, pvy_ff, pr_ff;
   // stage B: products
   logic        b_vld_ff, b_rot_zero_ff;
   logic [63:0] fx_ff, px_ff, vx_ff, fy_ff, py_ff, vy_ff, fr_ff, ar_ff, rr_ff;
   logic [63:0] ex2_ff, ey2_ff, evx2_ff, evy2_ff;
   // stage C: commands
   logic        c_vld_ff;
   logic [31:0] ccx_ff, ccy_ff, ccr_ff;
   // stage D: squares and scaled magnitudes
   logic        d_vld_ff, d_sx_ff, d_sy_ff;
   logic [63:0] sqx_ff, sqy_ff, numx_ff, numy_ff;
   logic [31:0] dcx_ff, dcy_ff, dcr_ff;
   logic [63:0] lim_sq_ff;
   htt_cell_type out_ff;

   logic [63:0] pos2, vel2, len2;
   logic        move_zero;
   logic [31:0] sum_x, sum_y, sum_r;
   logic [32:0] lim33;
   logic [31:0] clamp_r;

   always_comb begin
      pos2 = ex2_ff + ey2_ff;
      vel2 = evx2_ff + evy2_ff;
      move_zero = (pos2 <= MOVE_POS_TOL_SQ) && (vel2 <= MOVE_VEL_TOL_SQ);
      sum_x = sat64(64'($signed(fx_ff) >>> 16) + 64'($signed(px_ff) >>> 16)
                    + 64'($signed(vx_ff) >>> 16));
      sum_y = sat64(64'($signed(fy_ff) >>> 16) + 64'($signed(py_ff) >>> 16)
                    + 64'($signed(vy_ff) >>> 16));
      sum_r = sat64(64'($signed(fr_ff) >>> 16) + 64'($signed(ar_ff) >>> 16)
                    + 64'($signed(rr_ff) >>> 16));
      // clamp rotation to plus or minus its limit
      lim33 = {2'b00, cfg.turn_lim};
      if ($signed({ccr_ff[31], ccr_ff}) > $signed(lim33)) clamp_r = lim33[31:0];
      else if ($signed({ccr_ff[31], ccr_ff}) < -$signed(lim33)) clamp_r = 32'(-lim33);
      else clamp_r = ccr_ff;
      len2 = sqx_ff + sqy_ff;
   end

   always_ff @(posedge clock) begin
      lim_sq_ff <= 64'(cfg.move_lim) * 64'(cfg.move_lim);
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         out_ff.vld <= d_vld_ff;
      end
      if (en) begin
         // stage A
         ex_ff  <= sat_diff(in_item.plan_x, in_item.meas_x);
         ey_ff  <= sat_diff(in_item.plan_y, in_item.meas_y);
         evx_ff <= sat_diff(in_item.plan_vx, in_item.meas_vx);
         evy_ff <= sat_diff(in_item.plan_vy, in_item.meas_vy);
         ea_ff  <= sat_diff(in_item.plan_heading, in_item.meas_heading);
         er_ff  <= sat_diff(in_item.plan_turn_rate, in_item.meas_turn_rate);
         pvx_ff <= in_item.plan_vx;
         pvy_ff <= in_item.plan_vy;
         pr_ff  <= in_item.plan_turn_rate;
         // stage B
         fx_ff <= 64'($signed(pvx_ff) * $signed(cfg.move_ff));
         px_ff <= 64'($signed(ex_ff) * $signed(cfg.move_pos));
         vx_ff <= 64'($signed(evx_ff) * $signed(cfg.move_vel));
         fy_ff <= 64'($signed(pvy_ff) * $signed(cfg.move_ff));
         py_ff <= 64'($signed(ey_ff) * $signed(cfg.move_pos));
         vy_ff <= 64'($signed(evy_ff) * $signed(cfg.move_vel));
         fr_ff <= 64'($signed(pr_ff) * $signed(cfg.turn_ff));
         ar_ff <= 64'($signed(ea_ff) * $signed(cfg.turn_ang));
         rr_ff <= 64'($signed(er_ff) * $signed(cfg.turn_rate));
         ex2_ff  <= 64'($signed(ex_ff) * $signed(ex_ff));
         ey2_ff  <= 64'($signed(ey_ff) * $signed(ey_ff));
         evx2_ff <= 64'($signed(evx_ff) * $signed(evx_ff));
         evy2_ff <= 64'($signed(evy_ff) * $signed(evy_ff));
         b_rot_zero_ff <= (abs32(er_ff) <= TURN_RATE_TOL) && (abs32(ea_ff) <= TURN_ANGLE_TOL);
         // stage C
         ccx_ff <= move_zero ? '0 : sum_x;
         ccy_ff <= move_zero ? '0 : sum_y;
         ccr_ff <= b_rot_zero_ff ? '0 : sum_r;
         // stage D
         sqx_ff  <= 64'($signed(ccx_ff) * $signed(ccx_ff));
         sqy_ff  <= 64'($signed(ccy_ff) * $signed(ccy_ff));
         numx_ff <= 64'(abs32(ccx_ff)) * 64'(cfg.move_lim);
         numy_ff <= 64'(abs32(ccy_ff)) * 64'(cfg.move_lim);
         d_sx_ff <= ccx_ff[31];
         d_sy_ff <= ccy_ff[31];
         dcx_ff  <= ccx_ff;
         dcy_ff  <= ccy_ff;
         dcr_ff  <= clamp_r;
         // stage E: length test
         out_ff.sx   <= d_sx_ff;
         out_ff.sy   <= d_sy_ff;
         out_ff.over <= len2 > lim_sq_ff;
         out_ff.n    <= len2;
         out_ff.root <= '0;
         out_ff.remx <= numx_ff;
         out_ff.remy <= numy_ff;
         out_ff.qx   <= '0;
         out_ff.qy   <= '0;
         out_ff.cx   <= dcx_ff;
         out_ff.cy   <= dcy_ff;
         out_ff.cr   <= dcr_ff;
      end
   end

   assign out_cell = out_ff;

endmodule

/* src/htt_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// htt_sqrt_cell: one digit of the integer square root
// Tries one root bit against the running remainder and hands on.
// ----------------------------------------------------------------------------
module htt_sqrt_cell
   import htt_pkg::*;
#(
   parameter int SHIFT = 62
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  htt_cell_type in_cell,
   output htt_cell_type out_cell
);

   localparam logic [63:0] BIT = 64'd1 << SHIFT;

   htt_cell_type cell_ff, cell_in;
   logic [63:0]  trial;

   // subtract the trial when it fits, shift the root
   always_comb begin
      cell_in = in_cell;
      trial = in_cell.root + BIT;
      if (in_cell.n >= trial) begin
         cell_in.n    = in_cell.n - trial;
         cell_in.root = (in_cell.root >> 1) + BIT;
      end else begin
         cell_in.root = in_cell.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff.vld <= cell_in.vld;
      end
      if (en) begin
         cell_ff[$bits(htt_cell_type)-2:0] <= cell_in[$bits(htt_cell_type)-2:0];
      end
   end

   assign out_cell = cell_ff;

endmodule

/* src/htt_div_cell.sv */
// ----------------------------------------------------------------------------
// htt_div_cell: one quotient bit of the speed-limit scaling
// Restoring division of both scaled magnitudes by the vector length.
// The last cell of the row applies the sign and picks the scaled command.
// ----------------------------------------------------------------------------
module htt_div_cell
   import htt_pkg::*;
#(
   parameter int SHIFT = 30
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  htt_cell_type in_cell,
   output htt_cell_type out_cell
);

   htt_cell_type cell_ff, cell_in;
   logic [63:0]  dvs;

   always_comb begin
      cell_in = in_cell;
      dvs = {32'd0, in_cell.root[31:0]} << SHIFT;
      if (in_cell.remx >= dvs) begin
         cell_in.remx = in_cell.remx - dvs;
         cell_in.qx[SHIFT] = 1'b1;
      end
      if (in_cell.remy >= dvs) begin
         cell_in.remy = in_cell.remy - dvs;
         cell_in.qy[SHIFT] = 1'b1;
      end
      // finish: replace the command by the scaled one
      if (SHIFT == 0 && in_cell.over) begin
         cell_in.cx = in_cell.sx ? 32'(-{1'b0, cell_in.qx}) : {1'b0, cell_in.qx};
         cell_in.cy = in_cell.sy ? 32'(-{1'b0, cell_in.qy}) : {1'b0, cell_in.qy};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff.vld <= cell_in.vld;
      end
      if (en) begin
         cell_ff[$bits(htt_cell_type)-2:0] <= cell_in[$bits(htt_cell_type)-2:0];
      end
   end

   assign out_cell = cell_ff;

endmodule

/* src/holonomic_trajectory_tracker_top.sv */
// Path from accepted request to response: 5 front stages,
// 32 square-root cells, 31 divider cells, the last one being the output register.
// Throughput: one item per cycle; the whole row advances whenever the output
// register is empty or being taken, so a held response stalls every stage.
// Reset: clears valid bits and loads register reset values; no clearing pass.
// ----------------------------------------------------------------------------
// holonomic_trajectory_tracker_top: feedforward plus PD tracking controller
// Translation and rotation commands from plan and measurement, with
// tolerance dead zone, saturation and speed limiting.
// ----------------------------------------------------------------------------
module holonomic_trajectory_tracker_top
   import htt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   htt_req_if.sink    req_ch,
   htt_rsp_if.source  rsp_ch,
   htt_csr_if.sink    csr_ch
);

   htt_cfg_type  cfg_ff;
   htt_in_type   in_item;
   logic         en;
   htt_cell_type front_cell;
   htt_cell_type sq_cell [SQRT_CELLS+1];
   htt_cell_type dv_cell [DIV_CELLS+1];

   // register writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_ff   <= 32'd65536;
         cfg_ff.move_pos  <= 32'd0;
         cfg_ff.move_vel  <= 32'd0;
         cfg_ff.turn_ff   <= 32'd65536;
         cfg_ff.turn_ang  <= 32'd0;
         cfg_ff.turn_rate <= 32'd0;
         cfg_ff.move_lim  <= 31'd131072;
         cfg_ff.turn_lim  <= 31'd131072;
      end else if (csr_ch.valid) begin
         unique case (htt_csr_type'(csr_ch.index))
            CSR_MOVE_FF_GAIN:   cfg_ff.move_ff   <= csr_ch.data;
            CSR_MOVE_POS_GAIN:  cfg_ff.move_pos  <= csr_ch.data;
            CSR_MOVE_VEL_GAIN:  cfg_ff.move_vel  <= csr_ch.data;
            CSR_TURN_FF_GAIN:   cfg_ff.turn_ff   <= csr_ch.data;
            CSR_TURN_ANG_GAIN:  cfg_ff.turn_ang  <= csr_ch.data;
            CSR_TURN_RATE_GAIN: cfg_ff.turn_rate <= csr_ch.data;
            CSR_MOVE_LIMIT:     cfg_ff.move_lim  <= csr_ch.data[30:0];
            CSR_TURN_LIMIT:     cfg_ff.turn_lim  <= csr_ch.data[30:0];
            default: ;
         endcase
      end
   end

   // advance when the output register is free or taken
   assign en = !dv_cell[DIV_CELLS].vld || rsp_ch.ready;
   assign req_ch.ready = en;

   assign in_item = '{plan_x: req_ch.plan_x, plan_y: req_ch.plan_y,
      plan_vx: req_ch.plan_vx, plan_vy: req_ch.plan_vy,
      plan_heading: req_ch.plan_heading, plan_turn_rate: req_ch.plan_turn_rate,
      meas_x: req_ch.meas_x, meas_y: req_ch.meas_y, meas_vx: req_ch.meas_vx,
      meas_vy: req_ch.meas_vy, meas_heading: req_ch.meas_heading,
      meas_turn_rate: req_ch.meas_turn_rate};

   htt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_ch.valid),
      .in_item  (in_item),
      .cfg      (cfg_ff),
      .out_cell (front_cell)
   );

   assign sq_cell[0] = front_cell;

   // square-root row, highest root bit first
   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      htt_sqrt_cell #(.SHIFT(62 - 2 * k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_cell  (sq_cell[k]),
         .out_cell (sq_cell[k+1])
      );
   end

   assign dv_cell[0] = sq_cell[SQRT_CELLS];

   // divider row, highest quotient bit first
   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      htt_div_cell #(.SHIFT(DIV_CELLS - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_cell  (dv_cell[k]),
         .out_cell (dv_cell[k+1])
      );
   end

   assign rsp_ch.valid         = dv_cell[DIV_CELLS].vld;
   assign rsp_ch.cmd_vx        = dv_cell[DIV_CELLS].cx;
   assign rsp_ch.cmd_vy        = dv_cell[DIV_CELLS].cy;
   assign rsp_ch.cmd_turn_rate = dv_cell[DIV_CELLS].cr;

   // no response right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   // a stalled row keeps its items
   assert property (@(posedge clock) disable iff (reset)
      !en && sq_cell[1].vld |=> sq_cell[1].vld)
      else $error("item lost in stalled square-root row");

   // hold a waiting response until it is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.cmd_vx)
         && $stable(rsp_ch.cmd_vy) && $stable(rsp_ch.cmd_turn_rate))
      else $error("waiting response changed before it was taken");

endmodule
